FILE: rtl/rtcsrd_pkg.sv
// Shared types, constants and helper functions of the RTC stable-read decoder.
package rtcsrd_pkg;

   // Default number of re-reads allowed after the opening snapshot.
   localparam int MAX_ATTEMPTS_DEFAULT = 50;
   // Re-read counter width, fixed by the largest allowed attempt count.
   localparam int COUNT_W = 7;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTURY_PRESENT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEFAULT_YEAR    = 1'd1;
   localparam logic [13:0] DEFAULT_YEAR_RESET  = 14'd2021;
   localparam logic [13:0] CENTURY_BASE_RESET  = 14'd2000;

   // Division of a 14-bit year by 100: multiply by ceil(2^19 / 100), shift by 19.
   // The error stays below one hundredth for every 14-bit value, so it is exact.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // Format byte (status register B) bits and the hours register PM flag.
   localparam int FMT_BINARY_BIT = 2;
   localparam int FMT_24H_BIT    = 1;
   localparam int PM_BIT         = 7;
   localparam logic [7:0] HOURS_HALF_DAY = 8'd12;
   localparam logic [14:0] YEARS_CENTURY = 15'd100;

   // Result status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Decoupling queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // What the front end does with one input beat.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_OPEN,
      ACT_IGNORE,
      ACT_EMIT,
      ACT_FAIL,
      ACT_RETRY
   } action_type;

   typedef struct packed {
      logic        century_present;
      logic [13:0] default_year;
      logic [13:0] century_base;
   } cfg_type;

   // Queue entry: the matching snapshot still in raw form, or a failure marker.
   typedef struct packed {
      logic        status;
      logic [7:0]  raw_second;
      logic [7:0]  raw_minute;
      logic [7:0]  raw_hour;
      logic [7:0]  raw_day;
      logic [7:0]  raw_month;
      logic [7:0]  raw_year;
      logic [7:0]  raw_century;
      logic [7:0]  format_byte;
      logic [63:0] counter_value;
   } entry_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  second;
      logic [7:0]  minute;
      logic [7:0]  hour;
      logic [7:0]  day;
      logic [7:0]  month;
      logic [14:0] full_year;
      logic [63:0] counter_sync;
   } result_type;

   // Packed BCD to binary, low nibble plus ten times the high nibble, unchecked.
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      logic [3:0] hi;
      hi = v[7:4];
      return {4'b0, v[3:0]} + {1'b0, hi, 3'b0} + {3'b0, hi, 1'b0};
   endfunction

endpackage

FILE: rtl/rtcsrd_req_if.sv
// Snapshot channel: valid/ready handshake carrying one raw clock snapshot.
interface rtcsrd_req_if;
   logic        valid;
   logic        ready;
   logic        start_req;
   logic [7:0]  raw_second;
   logic [7:0]  raw_minute;
   logic [7:0]  raw_hour;
   logic [7:0]  raw_day;
   logic [7:0]  raw_month;
   logic [7:0]  raw_year;
   logic [7:0]  raw_century;
   logic [7:0]  format_byte;
   logic [63:0] counter_value;

   modport source (
      output valid, start_req, raw_second, raw_minute, raw_hour, raw_day,
             raw_month, raw_year, raw_century, format_byte, counter_value,
      input  ready
   );
   modport sink (
      input  valid, start_req, raw_second, raw_minute, raw_hour, raw_day,
             raw_month, raw_year, raw_century, format_byte, counter_value,
      output ready
   );
endinterface

FILE: rtl/rtcsrd_rsp_if.sv
// Result channel: valid/ready handshake carrying one decoded date or a failure.
interface rtcsrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [7:0]  second;
   logic [7:0]  minute;
   logic [7:0]  hour;
   logic [7:0]  day;
   logic [7:0]  month;
   logic [14:0] full_year;
   logic [63:0] counter_sync;

   modport source (
      output valid, status, second, minute, hour, day, month, full_year,
             counter_sync,
      input  ready
   );
   modport sink (
      input  valid, status, second, minute, hour, day, month, full_year,
             counter_sync,
      output ready
   );
endinterface

FILE: rtl/rtc_stable_read_decoder_core.sv
// Top level of the RTC stable-read checker and date decoder.
//
//   Channel   Direction  Handshake             Carries
//   req_if    in         valid/ready           one raw clock snapshot per beat
//   rsp_if    out        valid/ready           one decoded date or failure beat
//   csr_*     in         write enable only     century_present, default_year
//
// One snapshot beat is taken every cycle while the two-entry queue has room.
// A result beat is held in the queue, then in the output register, before it shows on rsp_if.
// The front end sets the pace: compare and classify are combinational.
// Reset is synchronous and active high; it closes any open sequence, empties the
// queue and the output register, and restores the configuration defaults.
// A stall on rsp_if fills the output register, then the queue, then drops
// req_if.ready; no beat is lost or repeated.
module rtc_stable_read_decoder_core #(
   parameter int MAX_ATTEMPTS = rtcsrd_pkg::MAX_ATTEMPTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   rtcsrd_req_if.sink                          req_if,
   rtcsrd_rsp_if.source                        rsp_if,
   input  logic                                csr_we,
   input  logic [rtcsrd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rtcsrd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rtcsrd_pkg::cfg_type   cfg;
   rtcsrd_pkg::entry_type push_entry;
   rtcsrd_pkg::entry_type pop_entry;
   logic                  push;
   logic                  push_ready;
   logic                  pop;
   logic                  pop_valid;

   // Configuration registers. The century base of the default year is
   // computed as the year is written, so the decoder only adds and compares.
   rtcsrd_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Front end: holds the previous snapshot and the re-read count, and decides
   // for each beat whether it opens, retries, matches or exhausts a sequence, or is ignored.
   rtcsrd_front #(
      .MAX_ATTEMPTS (MAX_ATTEMPTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_if      (req_if),
      .queue_ready (push_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Queue so that a stalled result side does not stop the front end at once.
   rtcsrd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Back end: BCD and hour conversion, year forming, output register.
   rtcsrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: rtl/rtcsrd_regs.sv
// Configuration registers, with the century base of the default year precomputed.
module rtcsrd_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rtcsrd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rtcsrd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rtcsrd_pkg::cfg_type                 cfg
);

   rtcsrd_pkg::cfg_type cfg_ff, cfg_in;
   logic [26:0] recip_prod;
   logic [7:0]  century_q;
   logic [13:0] base_new;

   // Century base = floor(year / 100) * 100, taken when the year is written.
   always_comb begin
      recip_prod = {13'b0, csr_wdata} * {14'b0, rtcsrd_pkg::RECIP_100};
      century_q  = recip_prod[26:rtcsrd_pkg::RECIP_SHIFT];
      base_new   = {century_q, 6'b0} + {1'b0, century_q, 5'b0} + {4'b0, century_q, 2'b0};
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rtcsrd_pkg::REG_CENTURY_PRESENT: begin
               cfg_in.century_present = csr_wdata[0];
            end
            rtcsrd_pkg::REG_DEFAULT_YEAR: begin
               cfg_in.default_year = csr_wdata;
               cfg_in.century_base = base_new;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.century_present <= 1'b0;
         cfg_ff.default_year    <= rtcsrd_pkg::DEFAULT_YEAR_RESET;
         cfg_ff.century_base    <= rtcsrd_pkg::CENTURY_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/rtcsrd_front.sv
// Front end: accepts snapshots, compares with the stored one and tracks re-reads.
module rtcsrd_front #(
   parameter int MAX_ATTEMPTS = rtcsrd_pkg::MAX_ATTEMPTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rtcsrd_pkg::cfg_type   cfg,
   rtcsrd_req_if.sink            req_if,
   input  logic                  queue_ready,
   output logic                  push,
   output rtcsrd_pkg::entry_type push_entry
);

   localparam logic [rtcsrd_pkg::COUNT_W-1:0] MAX_COUNT = rtcsrd_pkg::COUNT_W'(MAX_ATTEMPTS);

   logic [55:0]                      snap_ff, snap_in;
   logic [rtcsrd_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                             active_ff, active_in;
   logic [55:0]                      snap_now;
   logic [7:0]                       century_m;
   logic                             accept;
   rtcsrd_pkg::action_type           action;

   assign req_if.ready = queue_ready;
   assign accept       = req_if.valid & queue_ready;

   // The century byte takes part in the comparison only when it exists.
   assign century_m = cfg.century_present ? req_if.raw_century : 8'h00;
   assign snap_now  = {req_if.raw_second, req_if.raw_minute, req_if.raw_hour,
                       req_if.raw_day, req_if.raw_month, req_if.raw_year, century_m};

   // Classify the beat.
   always_comb begin
      if (!accept) begin
         action = rtcsrd_pkg::ACT_NONE;
      end else if (req_if.start_req) begin
         action = rtcsrd_pkg::ACT_OPEN;
      end else if (!active_ff) begin
         action = rtcsrd_pkg::ACT_IGNORE;
      end else if (snap_now == snap_ff) begin
         action = rtcsrd_pkg::ACT_EMIT;
      end else if (count_ff >= MAX_COUNT) begin
         action = rtcsrd_pkg::ACT_FAIL;
      end else begin
         action = rtcsrd_pkg::ACT_RETRY;
      end
   end

   // State update and queue push for each class.
   always_comb begin
      snap_in   = snap_ff;
      count_in  = count_ff;
      active_in = active_ff;
      push      = 1'b0;
      case (action)
         rtcsrd_pkg::ACT_OPEN: begin
            snap_in   = snap_now;
            count_in  = '0;
            active_in = 1'b1;
         end
         rtcsrd_pkg::ACT_EMIT, rtcsrd_pkg::ACT_FAIL: begin
            count_in  = '0;
            active_in = 1'b0;
            push      = 1'b1;
         end
         rtcsrd_pkg::ACT_RETRY: begin
            snap_in  = snap_now;
            count_in = count_ff + 1'b1;
         end
         default: begin
            snap_in = snap_ff;
         end
      endcase
   end

   always_comb begin
      push_entry.status        = (action == rtcsrd_pkg::ACT_FAIL) ?
                                 rtcsrd_pkg::STATUS_FAIL : rtcsrd_pkg::STATUS_OK;
      push_entry.raw_second    = req_if.raw_second;
      push_entry.raw_minute    = req_if.raw_minute;
      push_entry.raw_hour      = req_if.raw_hour;
      push_entry.raw_day       = req_if.raw_day;
      push_entry.raw_month     = req_if.raw_month;
      push_entry.raw_year      = req_if.raw_year;
      push_entry.raw_century   = century_m;
      push_entry.format_byte   = req_if.format_byte;
      push_entry.counter_value = req_if.counter_value;
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

   // A finished sequence leaves nothing active behind.
   a_push_closes: assert property (@(posedge clock) disable iff (reset)
      push |=> !active_ff && (count_ff == '0))
      else $error("sequence still active after a result was queued");

   // The re-read count never runs past the allowed number of attempts.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("re-read count above limit");

endmodule

FILE: rtl/rtcsrd_fifo.sv
// Short queue between the front end and the decoder.
module rtcsrd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rtcsrd_pkg::entry_type push_entry,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  pop_valid,
   output rtcsrd_pkg::entry_type pop_entry
);

   localparam int PTR_W = $clog2(rtcsrd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(rtcsrd_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rtcsrd_pkg::QUEUE_DEPTH);

   rtcsrd_pkg::entry_type       slot_ff [rtcsrd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            fill_ff, fill_in;

   assign push_ready = (fill_ff != DEPTH_C);
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(rtcsrd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid && (fill_ff <= DEPTH_C))
      else $error("pop from an empty queue");

endmodule

FILE: rtl/rtcsrd_back.sv
// Back end: decodes queued snapshots into the registered result beat.
module rtcsrd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rtcsrd_pkg::cfg_type   cfg,
   input  logic                  entry_valid,
   input  rtcsrd_pkg::entry_type entry,
   output logic                  pop,
   rtcsrd_rsp_if.source          rsp_if
);

   logic                   valid_ff, valid_in;
   rtcsrd_pkg::result_type out_ff, out_in;
   rtcsrd_pkg::result_type decoded;
   logic                   is_binary;
   logic [7:0]             sec_d, min_d, hour_b, hour_d, day_d, month_d, year_d, cen_d;
   logic [7:0]             hour_low;
   logic [14:0]            cen15, year_cent, year_guess;

   assign is_binary = entry.format_byte[rtcsrd_pkg::FMT_BINARY_BIT];

   always_comb begin
      if (is_binary) begin
         sec_d   = entry.raw_second;
         min_d   = entry.raw_minute;
         hour_b  = entry.raw_hour;
         day_d   = entry.raw_day;
         month_d = entry.raw_month;
         year_d  = entry.raw_year;
         cen_d   = entry.raw_century;
      end else begin
         sec_d   = rtcsrd_pkg::bcd_to_bin(entry.raw_second);
         min_d   = rtcsrd_pkg::bcd_to_bin(entry.raw_minute);
         // Tens of hours are three bits; the PM flag rides along untouched.
         hour_b  = {4'b0, entry.raw_hour[3:0]} + {2'b0, entry.raw_hour[6:4], 3'b0}
                   + {4'b0, entry.raw_hour[6:4], 1'b0}
                   + {entry.raw_hour[rtcsrd_pkg::PM_BIT], 7'b0};
         day_d   = rtcsrd_pkg::bcd_to_bin(entry.raw_day);
         month_d = rtcsrd_pkg::bcd_to_bin(entry.raw_month);
         year_d  = rtcsrd_pkg::bcd_to_bin(entry.raw_year);
         cen_d   = rtcsrd_pkg::bcd_to_bin(entry.raw_century);
      end
   end

   // 12-hour to 24-hour: twelve means zero, PM adds twelve.
   always_comb begin
      hour_low = {1'b0, hour_b[6:0]};
      if (hour_low == rtcsrd_pkg::HOURS_HALF_DAY) begin
         hour_low = '0;
      end
      if (hour_b[rtcsrd_pkg::PM_BIT]) begin
         hour_low = hour_low + rtcsrd_pkg::HOURS_HALF_DAY;
      end
      hour_d = entry.format_byte[rtcsrd_pkg::FMT_24H_BIT] ? hour_b : hour_low;
   end

   // Year from the century byte, or the nearest year not before the default year.
   always_comb begin
      cen15      = {7'b0, cen_d};
      year_cent  = {7'b0, year_d} + (cen15 << 6) + (cen15 << 5) + (cen15 << 2);
      year_guess = {7'b0, year_d} + {1'b0, cfg.century_base};
      if (year_guess < {1'b0, cfg.default_year}) begin
         year_guess = year_guess + rtcsrd_pkg::YEARS_CENTURY;
      end
   end

   always_comb begin
      if (entry.status == rtcsrd_pkg::STATUS_FAIL) begin
         decoded        = '0;
         decoded.status = rtcsrd_pkg::STATUS_FAIL;
      end else begin
         decoded.status       = rtcsrd_pkg::STATUS_OK;
         decoded.second       = sec_d;
         decoded.minute       = min_d;
         decoded.hour         = hour_d;
         decoded.day          = day_d;
         decoded.month        = month_d;
         decoded.full_year    = cfg.century_present ? year_cent : year_guess;
         decoded.counter_sync = entry.counter_value;
      end
   end

   // The output register refills whenever it is empty or being drained.
   always_comb begin
      pop      = entry_valid & (~valid_ff | rsp_if.ready);
      valid_in = pop | (valid_ff & ~rsp_if.ready);
      out_in   = pop ? decoded : out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.status       = out_ff.status;
   assign rsp_if.second       = out_ff.second;
   assign rsp_if.minute       = out_ff.minute;
   assign rsp_if.hour         = out_ff.hour;
   assign rsp_if.day          = out_ff.day;
   assign rsp_if.month        = out_ff.month;
   assign rsp_if.full_year    = out_ff.full_year;
   assign rsp_if.counter_sync = out_ff.counter_sync;

endmodule
